// ===== sv/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Types and constants for the percentile gray level block.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned PCT_W = 14;

  localparam logic [PCT_W-1:0] PCT_FULL  = 14'd10000;
  localparam logic [PCT_W-1:0] PCT_RESET = 14'd9500;
  localparam logic [PIX_W-1:0] FALLBACK_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_WALK
  } hpt_state_t;

endpackage

// ===== sv/histogram_percentile_threshold.sv =====
// ----------------------------------------------------------------------------
// histogram_percentile_threshold
// Builds a histogram of an 8-bit frame and reports its percentile gray level.
// ----------------------------------------------------------------------------
// Pixels transfer one per clock while busy is low, and the histogram
// read-modify-write, with forwarding from the previous write, keeps that
// rate. On the pixel marked frame_end the block raises busy, lets the last
// write land, then walks the bins from level 0 upward, one bin read per
// cycle from the single histogram memory port; the walk stops early when
// the level is found. The result appears on out_threshold_level for exactly
// one cycle with out_valid high; the receiver cannot stall, so take it in
// that cycle. After reset and after every frame the histogram reads as zero
// at once: all per-bin valid flags are cleared together, so there is no
// clearing pass. Configuration (cfg_we/cfg_wdata) must be written only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module histogram_percentile_threshold #(
  parameter int unsigned MAX_PIXELS = 1048576,
  parameter int unsigned LEVELS     = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [hpt_pkg::PIX_W-1:0]  in_pixel_value,
  input  logic                       in_frame_end,
  output logic                       out_valid,
  output logic [hpt_pkg::PIX_W-1:0]  out_threshold_level,
  input  logic                       cfg_we,
  input  logic [hpt_pkg::PCT_W-1:0]  cfg_wdata
);
  import hpt_pkg::*;

  // Widths: bin count, bin index, walk counter, products and the running sum.
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned PW = CW + PCT_W;
  localparam int unsigned AW = PW + LW;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PIXELS);

  hpt_state_t state_r, state_nxt;

  logic [PCT_W-1:0] pct_r;
  logic [CW-1:0]    total_r;

  // Histogram memory with per-bin valid flags.
  logic [CW-1:0]    hist_mem [LEVELS];
  logic [LEVELS-1:0] bin_vld_r;
  logic [CW-1:0]    rd_q_r;
  logic [LW-1:0]    rd_addr;

  // Pixel update stage.
  logic             accept;
  logic [LW-1:0]    pix_idx;
  logic             s1_v_r;
  logic [LW-1:0]    s1_idx_r;
  logic             wr_v_r;
  logic [LW-1:0]    wr_idx_r;
  logic [CW-1:0]    wr_data_r;
  logic [CW-1:0]    old_cnt;
  logic [CW-1:0]    new_cnt;

  // Walk pipeline.
  logic [LW:0]      issue_cnt_r;
  logic             issue;
  logic             d1_v_r;
  logic [LW-1:0]    d1_idx_r;
  logic             d2_v_r;
  logic [LW-1:0]    d2_idx_r;
  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    target_r;
  logic [AW-1:0]    acc_r;
  logic [AW-1:0]    acc_nxt;
  logic [CW-1:0]    walk_bin;
  logic [PCT_W-1:0] pct_clamped;
  logic             hit;
  logic             last_bin;
  logic             done;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_level_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Fold levels beyond the top bin into it.
  always_comb begin
    if ({1'b0, in_pixel_value} >= (PIX_W+1)'(LEVELS)) begin
      pix_idx = LW'(LEVELS - 1);
    end else begin
      pix_idx = in_pixel_value[LW-1:0];
    end
  end

  // Pixels read at their own bin; the walk reads at its issue counter.
  assign rd_addr = (state_r == ST_IDLE) ? pix_idx : issue_cnt_r[LW-1:0];

  // Take the freshest count: the write of the cycle before beats the memory.
  always_comb begin
    if (wr_v_r && (wr_idx_r == s1_idx_r)) begin
      old_cnt = wr_data_r;
    end else if (bin_vld_r[s1_idx_r]) begin
      old_cnt = rd_q_r;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt >= CNT_MAX) ? CNT_MAX : old_cnt + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      hist_mem[s1_idx_r] <= new_cnt;
    end
    rd_q_r <= hist_mem[rd_addr];
  end

  // Walk arithmetic: scale each bin by the full-scale percentage, then
  // accumulate and compare against percentile times pixel total.
  assign issue       = (state_r == ST_WALK) && (issue_cnt_r < (LW+1)'(LEVELS));
  assign walk_bin    = bin_vld_r[d1_idx_r] ? rd_q_r : '0;
  assign pct_clamped = (pct_r > PCT_FULL) ? PCT_FULL : pct_r;
  assign acc_nxt     = acc_r + AW'(prod_r);
  assign hit         = d2_v_r && (acc_nxt >= AW'(target_r));
  assign last_bin    = d2_v_r && (d2_idx_r == LW'(LEVELS - 1));
  assign done        = (state_r == ST_WALK) && (hit || last_bin);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_frame_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pct_r       <= PCT_RESET;
      total_r     <= '0;
      bin_vld_r   <= '0;
      s1_v_r      <= 1'b0;
      wr_v_r      <= 1'b0;
      d1_v_r      <= 1'b0;
      d2_v_r      <= 1'b0;
      issue_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pct_r <= cfg_wdata;
      end

      // Pixel side: count the frame and mark the written bin live.
      s1_v_r <= accept;
      wr_v_r <= s1_v_r;
      if (accept) begin
        total_r <= (total_r >= CNT_MAX) ? CNT_MAX : total_r + CW'(1);
      end
      if (s1_v_r) begin
        bin_vld_r[s1_idx_r] <= 1'b1;
      end

      // Walk side.
      d1_v_r <= issue;
      d2_v_r <= d1_v_r && (state_r == ST_WALK);
      if (state_r == ST_DRAIN) begin
        issue_cnt_r <= '0;
      end else if (issue) begin
        issue_cnt_r <= issue_cnt_r + (LW+1)'(1);
      end

      // Drop the histogram and the count once the level is known.
      out_valid_r <= done;
      if (done) begin
        bin_vld_r <= '0;
        total_r   <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_idx_r  <= pix_idx;
    wr_idx_r  <= s1_idx_r;
    wr_data_r <= new_cnt;
    d1_idx_r  <= issue_cnt_r[LW-1:0];
    d2_idx_r  <= d1_idx_r;
    prod_r    <= PW'(walk_bin) * PW'(PCT_FULL);
    if (state_r == ST_DRAIN) begin
      target_r <= PW'(pct_clamped) * PW'(total_r);
      acc_r    <= '0;
    end else if (d2_v_r) begin
      acc_r <= acc_nxt;
    end
    if (hit) begin
      out_level_r <= PIX_W'(d2_idx_r);
    end else begin
      out_level_r <= FALLBACK_LEVEL;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_threshold_level = out_level_r;

endmodule

// ===== dv/histogram_percentile_threshold_test.sv =====
// ----------------------------------------------------------------------------
// histogram_percentile_threshold_test
// Self-checking bench for the percentile gray level block: frames of pixels
// are streamed in with random gaps, a local histogram predicts the level that
// each frame end must report, and every result is checked in arrival order.
// ----------------------------------------------------------------------------
module histogram_percentile_threshold_test;

  import hpt_pkg::*;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned LEVELS     = 256;
  // Worst-case busy stretch of one frame end, with some margin
  localparam int unsigned WALK_CYCLES = LEVELS + 8;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] in_pixel_value;
  logic             in_frame_end;
  logic             out_valid;
  logic [PIX_W-1:0] out_threshold_level;
  logic             cfg_we;
  logic [PCT_W-1:0] cfg_wdata;

  // Local picture of the block: histogram, pixel count and percentile setting
  int unsigned      bin_tally [LEVELS];
  int unsigned      frame_pixels;
  logic [PCT_W-1:0] pct_setting;

  // Levels still owed by the block, oldest first
  logic [PIX_W-1:0] expected_levels [$];

  logic [PIX_W-1:0] level_due;
  int               mismatches;
  int               drain_cycles;
  bit               gaps_on;

  histogram_percentile_threshold #(
    .MAX_PIXELS (MAX_PIXELS),
    .LEVELS     (LEVELS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel_value      (in_pixel_value),
    .in_frame_end        (in_frame_end),
    .out_valid           (out_valid),
    .out_threshold_level (out_threshold_level),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop in case the block hangs or never delivers a result
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Saturating increment shared by the bins and the frame counter
  function automatic int unsigned sat_bump(input int unsigned count);
    return (count >= MAX_PIXELS) ? MAX_PIXELS : count + 1;
  endfunction

  // Account for one accepted pixel; on the frame end walk the bins and queue
  // the level the block has to report, then clear for the next frame.
  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic last);
    int unsigned       bin;
    int unsigned       pct;
    longint unsigned   target;
    longint unsigned   running;
    logic [PIX_W-1:0]  level;
    bit                found;
    bin = pix;
    if (bin >= LEVELS) begin
      bin = LEVELS - 1;
    end
    bin_tally[bin] = sat_bump(bin_tally[bin]);
    frame_pixels   = sat_bump(frame_pixels);
    if (last) begin
      // Settings above full scale behave as full scale
      pct     = (pct_setting > PCT_FULL) ? PCT_FULL : pct_setting;
      target  = longint'(pct) * longint'(frame_pixels);
      running = 0;
      found   = 1'b0;
      level   = FALLBACK_LEVEL;
      for (int v = 0; v < LEVELS; v++) begin
        running += bin_tally[v];
        if (!found && running * PCT_FULL >= target) begin
          level = v[PIX_W-1:0];
          found = 1'b1;
        end
      end
      expected_levels.insert(expected_levels.size(), level);
      foreach (bin_tally[i]) begin
        bin_tally[i] = 0;
      end
      frame_pixels = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking: results cannot be held off, so take one whenever the
  // strobe is high and compare it with the oldest outstanding level.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_levels.size() == 0) begin
        $error("threshold_level: expected none, actual %0d", out_threshold_level);
        mismatches++;
      end else begin
        level_due = expected_levels.pop_front();
        if (out_threshold_level !== level_due) begin
          $error("threshold_level: expected %0d, actual %0d",
                 level_due, out_threshold_level);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Lower start at the next falling edge so no unpredicted pixel slips in
  task automatic drop_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Offer one pixel and hold it until the block takes it. While idling, keep
  // the data lines moving so the block is seen to ignore them.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 36) begin
        @(negedge clk);
        start          <= 1'b0;
        in_pixel_value <= PIX_W'($urandom);
        in_frame_end   <= 1'($urandom);
      end
    end
    @(negedge clk);
    start          <= 1'b1;
    in_pixel_value <= pix;
    in_frame_end   <= last;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    predict_pixel(pix, last);
  endtask

  // Hold off until every owed level has arrived, then let a full walk pass
  task automatic wait_results();
    drop_start();
    while (expected_levels.size() != 0) begin
      @(negedge clk);
    end
    repeat (WALK_CYCLES) @(negedge clk);
  endtask

  // Change the percentile only with the block idle
  task automatic write_percentile(input logic [PCT_W-1:0] value);
    wait_results();
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    pct_setting = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Run two frames on the percentile left by reset, with a one-pixel frame
  task automatic test_reset_percentile();
    for (int i = 0; i < 20; i++) begin
      send_pixel(PIX_W'(i), i == 19);
    end
    send_pixel(8'd255, 1'b1);
    drop_start();
  endtask

  // Cover zero, full scale and out-of-range settings with extreme pixels
  task automatic test_percentile_extremes();
    // Zero percentile reports level 0 even with bin 0 empty
    write_percentile('0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd7,   1'b0);
    send_pixel(8'd255, 1'b1);
    // Full scale needs every pixel, so the top pixel decides
    write_percentile(PCT_FULL);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd3,   1'b0);
    send_pixel(8'd255, 1'b1);
    // All ones and just above full scale both clamp to full scale
    write_percentile({PCT_W{1'b1}});
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd128, 1'b1);
    write_percentile(PCT_FULL + 14'd1);
    send_pixel(8'd1,   1'b0);
    send_pixel(8'd254, 1'b1);
    // Smallest non-zero setting lands on the first occupied bin
    write_percentile(14'd1);
    send_pixel(8'd90,  1'b0);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd170, 1'b1);
    drop_start();
  endtask

  // One well-formed frame with random length and a random pixel pattern
  task automatic send_random_frame(output int unsigned len);
    int unsigned      mode;
    int unsigned      base;
    logic [PIX_W-1:0] pix;
    mode = $urandom_range(0, 4);
    base = $urandom_range(0, 248);
    // Mostly short frames keep the walk overhead visible; a few long ones
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: begin
          pix = PIX_W'($urandom);
        end
        1: begin
          pix = PIX_W'(base + $urandom_range(0, 7));
        end
        2: begin
          pix = $urandom_range(0, 1) ? PIX_W'(base) : PIX_W'(255 - base);
        end
        3: begin
          pix = PIX_W'(base);
        end
        default: begin
          pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
      endcase
      send_pixel(pix, i == len - 1);
    end
  endtask

  // Random frames across several percentile settings, extremes included
  task automatic test_random_frames();
    logic [PCT_W-1:0] pct_list [8];
    int unsigned      phase_items;
    int unsigned      len;
    pct_list[0] = PCT_RESET;
    pct_list[1] = '0;
    pct_list[2] = PCT_FULL;
    pct_list[3] = {PCT_W{1'b1}};
    pct_list[4] = 14'd5000;
    pct_list[5] = 14'd9999;
    pct_list[6] = PCT_W'($urandom_range(0, 10000));
    pct_list[7] = PCT_W'($urandom_range(0, 16383));
    for (int ph = 0; ph < 8; ph++) begin
      // Phase 5 streams back to back with no random gaps between pixels
      gaps_on = (ph != 5);
      write_percentile(pct_list[ph]);
      phase_items = 0;
      while (phase_items < 250) begin
        send_random_frame(len);
        phase_items += len;
        // Now and then hold the stream until the block has caught up
        if ($urandom_range(0, 19) == 0) begin
          wait_results();
        end
      end
    end
    gaps_on = 1'b1;
    drop_start();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_pixel_value = '0;
    in_frame_end   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatches     = 0;
    gaps_on        = 1'b1;
    pct_setting    = PCT_RESET;
    frame_pixels   = 0;
    foreach (bin_tally[i]) begin
      bin_tally[i] = 0;
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_percentile();
    test_percentile_extremes();
    test_random_frames();

    // Drain: give the last frame end time to report, then a full walk more
    drop_start();
    drain_cycles = 0;
    while (expected_levels.size() != 0 && drain_cycles < 4 * WALK_CYCLES) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (WALK_CYCLES) @(negedge clk);
    if (expected_levels.size() != 0) begin
      $error("threshold_level: %0d expected results never arrived",
             expected_levels.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
